@@ hdl/vector4_fixed_point_alu_assert.svh @@
// assertion macros for the vector alu top level
`ifndef VECTOR4_FIXED_POINT_ALU_ASSERT_SVH
`define VECTOR4_FIXED_POINT_ALU_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, held off while reset is high
`define VFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also covers the reset cycles
`define VFA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VFA_ASSERT(lbl, prop, msg)
`define VFA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ hdl/vfa_pkg.sv @@
// shared types and operation codes for the vector alu
package vfa_pkg;

  // operation codes carried in req_type
  typedef enum logic [3:0] {
    OP_NEG   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_AVG   = 4'd3,
    OP_SCALE = 4'd4,
    OP_LERP  = 4'd5,
    OP_DOT   = 4'd6,
    OP_LEN   = 4'd7,
    OP_DIST  = 4'd8,
    OP_NORM  = 4'd9
  } op_t;

  // control that rides along with every word in the pipeline
  typedef struct packed {
    logic valid;
    op_t  op;
  } tag_t;

endpackage

@@ hdl/vfa_front.sv @@
// front pipeline: operand select, lane multiply, sums, rounding and clipping
module vfa_front #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic [3:0]                            req_type,
  input  logic signed [VALUE_WIDTH-1:0]         a_x,
  input  logic signed [VALUE_WIDTH-1:0]         a_y,
  input  logic signed [VALUE_WIDTH-1:0]         a_z,
  input  logic signed [VALUE_WIDTH-1:0]         a_w,
  input  logic signed [VALUE_WIDTH-1:0]         b_x,
  input  logic signed [VALUE_WIDTH-1:0]         b_y,
  input  logic signed [VALUE_WIDTH-1:0]         b_z,
  input  logic signed [VALUE_WIDTH-1:0]         b_w,
  input  logic signed [VALUE_WIDTH-1:0]         scalar_in,
  output vfa_pkg::tag_t                         tag_o,
  output logic signed [VALUE_WIDTH-1:0]         a_o [4],
  output logic signed [VALUE_WIDTH-1:0]         vres_o [4],
  output logic                                  vsat_o,
  output logic                                  dneg_o,
  output logic [2*VALUE_WIDTH+FRAC_BITS+3:0]    dm_o,
  output logic [2*VALUE_WIDTH+1:0]              sq_o
);
  import vfa_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + F + 4;
  localparam int SW = 2 * W + 2;
  localparam logic [PW-1:0] HNEG = PW'(1) << (W - 1);
  localparam logic [PW-1:0] HPOS = (PW'(1) << (W - 1)) - PW'(1);
  localparam logic [PW-1:0] FHALF = PW'(1) << (F - 1);

  typedef enum logic [1:0] {RND_NONE, RND_HALF, RND_FRAC} rnd_t;

  // stage 1: operand select
  logic signed [W-1:0]  ain [4];
  logic signed [W-1:0]  bin [4];
  logic signed [W:0]    te;
  op_t                  op_n;
  logic signed [W:0]    mx_n [4];
  logic signed [W:0]    my_n [4];
  logic signed [PW-1:0] base_n [4];
  logic                 addp_n;
  rnd_t                 rsel_n;

  assign ain  = '{a_x, a_y, a_z, a_w};
  assign bin  = '{b_x, b_y, b_z, b_w};
  assign te   = (W+1)'(scalar_in);
  assign op_n = op_t'(req_type);

  always_comb begin
    logic signed [W:0] ae, be, sm, df, bma, vv, mg;
    addp_n = (op_n == OP_SCALE) || (op_n == OP_LERP);
    case (op_n)
      OP_AVG: begin
        rsel_n = RND_HALF;
      end
      OP_SCALE, OP_LERP: begin
        rsel_n = RND_FRAC;
      end
      default: begin
        rsel_n = RND_NONE;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      ae  = (W+1)'(ain[i]);
      be  = (W+1)'(bin[i]);
      sm  = ae + be;
      df  = ae - be;
      bma = be - ae;
      vv  = (op_n == OP_DIST) ? df : ae;
      mg  = vv[W] ? -vv : vv;
      mx_n[i]   = '0;
      my_n[i]   = '0;
      base_n[i] = '0;
      case (op_n)
        OP_NEG: begin
          base_n[i] = PW'(-ae);
        end
        OP_ADD, OP_AVG: begin
          base_n[i] = PW'(sm);
        end
        OP_SUB: begin
          base_n[i] = PW'(df);
        end
        OP_SCALE: begin
          mx_n[i] = ae;
          my_n[i] = te;
        end
        OP_LERP: begin
          base_n[i] = PW'(ae) <<< F;
          mx_n[i]   = bma;
          my_n[i]   = te;
        end
        OP_DOT: begin
          mx_n[i] = ae;
          my_n[i] = be;
        end
        OP_LEN, OP_DIST, OP_NORM: begin
          mx_n[i] = mg;
          my_n[i] = mg;
        end
        default: ;
      endcase
    end
  end

  tag_t                 t1;
  logic signed [W-1:0]  a1 [4];
  logic signed [W:0]    mx1 [4];
  logic signed [W:0]    my1 [4];
  logic signed [PW-1:0] base1 [4];
  logic                 addp1;
  rnd_t                 rsel1;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
    end else if (adv) begin
      t1    <= '{valid: in_valid, op: op_n};
      a1    <= ain;
      mx1   <= mx_n;
      my1   <= my_n;
      base1 <= base_n;
      addp1 <= addp_n;
      rsel1 <= rsel_n;
    end
  end

  // stage 2: one multiplier per lane
  tag_t                  t2;
  logic signed [W-1:0]   a2 [4];
  logic signed [PW-1:0]  base2 [4];
  logic signed [2*W+1:0] prod2 [4];
  logic                  addp2;
  rnd_t                  rsel2;

  always_ff @(posedge clk) begin
    if (rst) begin
      t2.valid <= 1'b0;
    end else if (adv) begin
      t2    <= t1;
      a2    <= a1;
      base2 <= base1;
      addp2 <= addp1;
      rsel2 <= rsel1;
      for (int i = 0; i < 4; i++) begin
        prod2[i] <= mx1[i] * my1[i];
      end
    end
  end

  // stage 3: lane values and pair sums of the products
  tag_t                 t3;
  logic signed [W-1:0]  a3 [4];
  logic signed [PW-1:0] lv3 [4];
  logic signed [PW-1:0] s01;
  logic signed [PW-1:0] s23;
  rnd_t                 rsel3;

  always_ff @(posedge clk) begin
    if (rst) begin
      t3.valid <= 1'b0;
    end else if (adv) begin
      t3    <= t2;
      a3    <= a2;
      rsel3 <= rsel2;
      s01   <= PW'(prod2[0]) + PW'(prod2[1]);
      s23   <= PW'(prod2[2]) + PW'(prod2[3]);
      for (int i = 0; i < 4; i++) begin
        lv3[i] <= addp2 ? base2[i] + PW'(prod2[i]) : base2[i];
      end
    end
  end

  // stage 4: lane magnitude rounding, full sum
  logic [PW-1:0] m4_n [4];

  always_comb begin
    logic [PW-1:0] mag;
    for (int i = 0; i < 4; i++) begin
      mag = lv3[i][PW-1] ? PW'(-lv3[i]) : PW'(lv3[i]);
      case (rsel3)
        RND_HALF: begin
          m4_n[i] = (mag + PW'(1)) >> 1;
        end
        RND_FRAC: begin
          m4_n[i] = (mag + FHALF) >> F;
        end
        default: begin
          m4_n[i] = mag;
        end
      endcase
    end
  end

  tag_t                 t4;
  logic signed [W-1:0]  a4 [4];
  logic                 neg4 [4];
  logic [PW-1:0]        m4 [4];
  logic signed [PW-1:0] tot4;

  always_ff @(posedge clk) begin
    if (rst) begin
      t4.valid <= 1'b0;
    end else if (adv) begin
      t4   <= t3;
      a4   <= a3;
      m4   <= m4_n;
      tot4 <= s01 + s23;
      for (int i = 0; i < 4; i++) begin
        neg4[i] <= lv3[i][PW-1];
      end
    end
  end

  // stage 5: lane clipping, dot product rounding
  logic signed [W-1:0] vr_n [4];
  logic                vsat_n;
  logic [PW-1:0]       dmag;
  logic [PW-1:0]       dm_n;

  always_comb begin
    logic [PW-1:0] lim, mc;
    logic          st;
    vsat_n = 1'b0;
    for (int i = 0; i < 4; i++) begin
      lim     = neg4[i] ? HNEG : HPOS;
      st      = m4[i] > lim;
      mc      = st ? lim : m4[i];
      vr_n[i] = neg4[i] ? W'(-mc) : W'(mc);
      vsat_n  = vsat_n | st;
    end
  end

  assign dmag = tot4[PW-1] ? PW'(-tot4) : PW'(tot4);
  assign dm_n = (dmag + FHALF) >> F;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else if (adv) begin
      tag_o  <= t4;
      a_o    <= a4;
      vres_o <= vr_n;
      vsat_o <= vsat_n;
      dneg_o <= tot4[PW-1];
      dm_o   <= dm_n;
      sq_o   <= tot4[SW-1:0];
    end
  end

endmodule

@@ hdl/vfa_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module vfa_sqrt #(
  parameter int VALUE_WIDTH = 32,
  parameter int SIDE_WIDTH  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  vfa_pkg::tag_t            tag_i,
  input  logic [2*VALUE_WIDTH+1:0] s_i,
  input  logic [SIDE_WIDTH-1:0]    side_i,
  output vfa_pkg::tag_t            tag_o,
  output logic [VALUE_WIDTH:0]     root_o,
  output logic [SIDE_WIDTH-1:0]    side_o
);
  import vfa_pkg::*;

  localparam int RW = VALUE_WIDTH + 1;
  localparam int SW = 2 * RW;

  tag_t                  tg [RW];
  logic [SW-1:0]         sv [RW];
  logic [RW-1:0]         rt [RW];
  logic [RW:0]           rm [RW];
  logic [SIDE_WIDTH-1:0] sd [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    tag_t                  c_tg;
    logic [SW-1:0]         c_s;
    logic [RW-1:0]         c_r;
    logic [RW:0]           c_m;
    logic [SIDE_WIDTH-1:0] c_sd;
    logic [RW+2:0]         rem2;
    logic [RW+2:0]         trial;
    logic [RW+2:0]         diff;

    if (k == 0) begin : g_first
      assign c_tg = tag_i;
      assign c_s  = s_i;
      assign c_r  = '0;
      assign c_m  = '0;
      assign c_sd = side_i;
    end else begin : g_next
      assign c_tg = tg[k-1];
      assign c_s  = sv[k-1];
      assign c_r  = rt[k-1];
      assign c_m  = rm[k-1];
      assign c_sd = sd[k-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem2  = {c_m, c_s[SW-1 -: 2]};
    assign trial = {1'b0, c_r, 2'b01};
    assign diff  = rem2 - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k].valid <= 1'b0;
      end else if (adv) begin
        tg[k] <= c_tg;
        sv[k] <= c_s << 2;
        sd[k] <= c_sd;
        if (rem2 >= trial) begin
          rt[k] <= {c_r[RW-2:0], 1'b1};
          rm[k] <= diff[RW:0];
        end else begin
          rt[k] <= {c_r[RW-2:0], 1'b0};
          rm[k] <= rem2[RW:0];
        end
      end
    end
  end

  assign tag_o  = tg[RW-1];
  assign root_o = rt[RW-1];
  assign side_o = sd[RW-1];

endmodule

@@ hdl/vfa_div.sv @@
// pipelined restoring divide of the four lane magnitudes by the length
module vfa_div #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int SIDE_WIDTH  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  vfa_pkg::tag_t                 tag_i,
  input  logic [VALUE_WIDTH:0]          len_i,
  input  logic signed [VALUE_WIDTH-1:0] a_i [4],
  input  logic [SIDE_WIDTH-1:0]         side_i,
  output vfa_pkg::tag_t                 tag_o,
  output logic [VALUE_WIDTH:0]          len_o,
  output logic [FRAC_BITS:0]            q_o [4],
  output logic [SIDE_WIDTH-1:0]         side_o
);
  import vfa_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int RW = W + 1;
  localparam int QB = F + 1;
  localparam int NW = W + F + 1;

  tag_t                  tg [QB+1];
  logic [RW-1:0]         ln [QB+1];
  logic [RW-1:0]         rr [QB+1][4];
  logic [QB-1:0]         nl [QB+1][4];
  logic [QB-1:0]         qq [QB+1][4];
  logic [SIDE_WIDTH-1:0] sd [QB+1];

  // numerator with half the divisor added for rounding
  logic [NW-1:0] nn [4];

  always_comb begin
    logic [W-1:0] mg;
    for (int i = 0; i < 4; i++) begin
      mg    = a_i[i][W-1] ? W'(-a_i[i]) : W'(a_i[i]);
      nn[i] = NW'({mg, {F{1'b0}}}) + NW'(len_i >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tg[0].valid <= 1'b0;
    end else if (adv) begin
      tg[0] <= tag_i;
      ln[0] <= len_i;
      sd[0] <= side_i;
      for (int i = 0; i < 4; i++) begin
        rr[0][i] <= RW'(nn[i][NW-1:QB]);
        nl[0][i] <= nn[i][QB-1:0];
        qq[0][i] <= '0;
      end
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= QB; j++) begin : g_stage
    logic [RW:0] r2 [4];
    logic [RW:0] rd [4];
    logic        ge [4];
    logic [RW:0] lnx;

    assign lnx = {1'b0, ln[j-1]};

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        r2[i] = {rr[j-1][i], nl[j-1][i][QB-1]};
        ge[i] = r2[i] >= lnx;
        rd[i] = ge[i] ? r2[i] - lnx : r2[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[j].valid <= 1'b0;
      end else if (adv) begin
        tg[j] <= tg[j-1];
        ln[j] <= ln[j-1];
        sd[j] <= sd[j-1];
        for (int i = 0; i < 4; i++) begin
          rr[j][i] <= rd[i][RW-1:0];
          nl[j][i] <= nl[j-1][i] << 1;
          qq[j][i] <= {qq[j-1][i][QB-2:0], ge[i]};
        end
      end
    end
  end

  assign tag_o  = tg[QB];
  assign len_o  = ln[QB];
  assign side_o = sd[QB];
  assign q_o    = qq[QB];

endmodule

@@ hdl/vector4_fixed_point_alu.sv @@
// top level of the four-component fixed-point vector alu
//
//   channel | signals                                  | role
//   --------+------------------------------------------+---------------------
//   in      | in_valid in_ready req_type a_* b_* scal. | operation word in
//   out     | out_valid out_ready res_* saturated      | result word out
//
// one word enters per cycle unless the output word is held; the pipeline has
// five front stages, VALUE_WIDTH + 1 square-root stages, FRAC_BITS + 2
// divide stages and the output register; the root and divide chains set its depth.
// reset clears the valid bit of every stage and of the output register.
// a stalled output word freezes every stage at once, so nothing is lost.
`include "vector4_fixed_point_alu_assert.svh"
module vector4_fixed_point_alu #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    req_type,
  input  logic signed [VALUE_WIDTH-1:0] a_x,
  input  logic signed [VALUE_WIDTH-1:0] a_y,
  input  logic signed [VALUE_WIDTH-1:0] a_z,
  input  logic signed [VALUE_WIDTH-1:0] a_w,
  input  logic signed [VALUE_WIDTH-1:0] b_x,
  input  logic signed [VALUE_WIDTH-1:0] b_y,
  input  logic signed [VALUE_WIDTH-1:0] b_z,
  input  logic signed [VALUE_WIDTH-1:0] b_w,
  input  logic signed [VALUE_WIDTH-1:0] scalar_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] res_x,
  output logic signed [VALUE_WIDTH-1:0] res_y,
  output logic signed [VALUE_WIDTH-1:0] res_z,
  output logic signed [VALUE_WIDTH-1:0] res_w,
  output logic signed [VALUE_WIDTH-1:0] res_scalar,
  output logic                          saturated
);
  import vfa_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int PW    = 2 * W + F + 4;
  localparam int RW    = W + 1;
  localparam int QB    = F + 1;
  localparam int LW    = W + F + 1;
  localparam int SIDEW = 8 * W + 2 + PW;
  localparam int VOFF  = PW + 2;
  localparam int AOFF  = PW + 2 + 4 * W;
  localparam logic [PW-1:0] HNEG_P = PW'(1) << (W - 1);
  localparam logic [PW-1:0] HPOS_P = (PW'(1) << (W - 1)) - PW'(1);
  localparam logic [RW-1:0] HPOS_R = (RW'(1) << (W - 1)) - RW'(1);
  localparam logic [LW-1:0] HNEG_L = LW'(1) << (W - 1);
  localparam logic [LW-1:0] HPOS_L = (LW'(1) << (W - 1)) - LW'(1);

  // whole pipeline moves unless the output word is held
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // front stages
  tag_t                f_tag;
  logic signed [W-1:0] f_a [4];
  logic signed [W-1:0] f_v [4];
  logic                f_vsat;
  logic                f_dneg;
  logic [PW-1:0]       f_dm;
  logic [2*W+1:0]      f_sq;
  logic [SIDEW-1:0]    f_side;

  vfa_front #(
    .VALUE_WIDTH(W),
    .FRAC_BITS(F)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(in_valid),
    .req_type(req_type),
    .a_x(a_x),
    .a_y(a_y),
    .a_z(a_z),
    .a_w(a_w),
    .b_x(b_x),
    .b_y(b_y),
    .b_z(b_z),
    .b_w(b_w),
    .scalar_in(scalar_in),
    .tag_o(f_tag),
    .a_o(f_a),
    .vres_o(f_v),
    .vsat_o(f_vsat),
    .dneg_o(f_dneg),
    .dm_o(f_dm),
    .sq_o(f_sq)
  );

  assign f_side = {f_a[0], f_a[1], f_a[2], f_a[3],
                   f_v[0], f_v[1], f_v[2], f_v[3], f_vsat, f_dneg, f_dm};

  // square root of the sum of squares
  tag_t                s_tag;
  logic [RW-1:0]       s_root;
  logic [SIDEW-1:0]    s_side;
  logic signed [W-1:0] s_a [4];

  vfa_sqrt #(
    .VALUE_WIDTH(W),
    .SIDE_WIDTH(SIDEW)
  ) u_sqrt (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .tag_i(f_tag),
    .s_i(f_sq),
    .side_i(f_side),
    .tag_o(s_tag),
    .root_o(s_root),
    .side_o(s_side)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s_a[i] = s_side[AOFF + (3 - i) * W +: W];
    end
  end

  // normalize divide
  tag_t                d_tag;
  logic [RW-1:0]       d_len;
  logic [QB-1:0]       d_q [4];
  logic [SIDEW-1:0]    d_side;
  logic signed [W-1:0] d_a [4];
  logic signed [W-1:0] d_vres [4];
  logic                d_vsat;
  logic                d_dneg;
  logic [PW-1:0]       d_dm;

  vfa_div #(
    .VALUE_WIDTH(W),
    .FRAC_BITS(F),
    .SIDE_WIDTH(SIDEW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .tag_i(s_tag),
    .len_i(s_root),
    .a_i(s_a),
    .side_i(s_side),
    .tag_o(d_tag),
    .len_o(d_len),
    .q_o(d_q),
    .side_o(d_side)
  );

  assign d_dm   = d_side[PW-1:0];
  assign d_dneg = d_side[PW];
  assign d_vsat = d_side[PW+1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d_vres[i] = d_side[VOFF + (3 - i) * W +: W];
      d_a[i]    = d_side[AOFF + (3 - i) * W +: W];
    end
  end

  // scalar clipping
  logic [PW-1:0]       dlim;
  logic                dsat;
  logic [PW-1:0]       dclip;
  logic signed [W-1:0] dres;
  logic                lsat;
  logic signed [W-1:0] lres;

  assign dlim  = d_dneg ? HNEG_P : HPOS_P;
  assign dsat  = d_dm > dlim;
  assign dclip = dsat ? dlim : d_dm;
  assign dres  = d_dneg ? W'(-dclip) : W'(dclip);
  assign lsat  = d_len > HPOS_R;
  assign lres  = lsat ? W'(HPOS_R) : W'(d_len);

  // normalize lane sign and clipping
  logic signed [W-1:0] nrm [4];
  logic                nsat;

  always_comb begin
    logic [LW-1:0] qz, lim, qc;
    logic          st;
    nsat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      qz     = LW'(d_q[i]);
      lim    = d_a[i][W-1] ? HNEG_L : HPOS_L;
      st     = qz > lim;
      qc     = st ? lim : qz;
      nrm[i] = d_a[i][W-1] ? W'(-qc) : W'(qc);
      nsat   = nsat | st;
    end
  end

  // result select by operation
  logic signed [W-1:0] o_v [4];
  logic signed [W-1:0] o_s;
  logic                o_sat;

  always_comb begin
    o_v   = '{default: '0};
    o_s   = '0;
    o_sat = 1'b0;
    case (d_tag.op)
      OP_NEG, OP_ADD, OP_SUB, OP_AVG, OP_SCALE, OP_LERP: begin
        o_v   = d_vres;
        o_sat = d_vsat;
      end
      OP_DOT: begin
        o_s   = dres;
        o_sat = dsat;
      end
      OP_LEN, OP_DIST: begin
        o_s   = lres;
        o_sat = lsat;
      end
      OP_NORM: begin
        if (d_len == '0) begin
          o_v = d_a;
        end else begin
          o_v   = nrm;
          o_sat = nsat;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid  <= d_tag.valid;
      res_x      <= o_v[0];
      res_y      <= o_v[1];
      res_z      <= o_v[2];
      res_w      <= o_v[3];
      res_scalar <= o_s;
      saturated  <= o_sat;
    end
  end

  `VFA_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "output valid after reset")
  `VFA_ASSERT(a_len_nonneg, (adv && d_tag.valid && (d_tag.op == OP_LEN || d_tag.op == OP_DIST)) |=> !res_scalar[W-1], "negative length")
  `VFA_ASSERT(a_vec_no_scalar, (adv && d_tag.valid && d_tag.op <= OP_LERP) |=> res_scalar == '0, "scalar set on vector op")
  `VFA_ASSERT(a_bad_op_zero, (adv && d_tag.valid && d_tag.op > OP_NORM) |=> (!saturated && res_x == '0 && res_scalar == '0), "undefined op not zero")

endmodule
